[rtl/core/cau_pkg.sv]
// shared types, constants and saturation helper for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 64 + FRAC_BITS;   // shifted dividend magnitude
    localparam int DIV_STEPS = 32;               // quotient bits below the overflow check
    localparam int DIV_LAT   = DIV_STEPS + 2;    // prep stage, steps, output stage
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_DIVZ = 2'd2;

    typedef struct packed {
        action_t            action;
        logic               div_zero;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    localparam logic signed [64:0] MAX65 = 65'sd2147483647;
    localparam logic signed [64:0] MIN65 = -65'sd2147483648;

    function automatic sat_t sat32(input logic signed [64:0] v);
        sat_t r;
        if (v > MAX65) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (v < MIN65) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/cau_front.sv]
// front end: accepts items, classifies the operation and flags a zero divisor
// depends on cau_pkg
module cau_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output cau_pkg::item_t q_item
);
    import cau_pkg::*;

    logic  front_valid_reg;
    item_t front_item_reg;
    item_t front_item_next;

    assign s_tready = !front_valid_reg || !q_full;
    assign q_push   = front_valid_reg && !q_full;
    assign q_item   = front_item_reg;

    always_comb begin
        front_item_next.action   = action_t'(s_tuser);
        front_item_next.a_real   = s_tdata[31:0];
        front_item_next.a_imag   = s_tdata[63:32];
        front_item_next.b_real   = s_tdata[95:64];
        front_item_next.b_imag   = s_tdata[127:96];
        front_item_next.div_zero = (s_tdata[127:64] == 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_tready) begin
            front_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            front_item_reg <= front_item_next;
        end
    end
endmodule

[rtl/core/cau_fifo.sv]
// short item queue between front and back end
// depends on cau_pkg
module cau_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cau_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output cau_pkg::item_t pop_item,
    output logic           empty
);
    import cau_pkg::*;

    item_t              slot_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

[rtl/core/cau_div.sv]
// pipelined restoring divider: signed numerator shifted by the fraction bits
// over an unsigned divisor, quotient toward zero, saturated to 32 bits
// depends on cau_pkg
module cau_div (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [64:0] num,
    input  logic [63:0]        den,
    output logic [31:0]        quo,
    output logic               sat
);
    import cau_pkg::*;

    logic [63:0] rem_reg  [0:DIV_STEPS];
    logic [63:0] rem_next [0:DIV_STEPS];
    logic [31:0] low_reg  [0:DIV_STEPS];
    logic [31:0] low_next [0:DIV_STEPS];
    logic [31:0] q_reg    [0:DIV_STEPS];
    logic [31:0] q_next   [0:DIV_STEPS];
    logic [63:0] den_reg  [0:DIV_STEPS];
    logic [63:0] den_next [0:DIV_STEPS];
    logic        neg_reg  [0:DIV_STEPS];
    logic        neg_next [0:DIV_STEPS];
    logic        over_reg [0:DIV_STEPS];
    logic        over_next[0:DIV_STEPS];
    logic [31:0] quo_reg, quo_next;
    logic        sat_reg, sat_next;

    logic [64:0]      mag;
    logic [NUM_W-1:0] shifted;
    logic [63:0]      top;
    logic [64:0]      trial [1:DIV_STEPS];
    logic             ge    [1:DIV_STEPS];
    logic [31:0]      limit;
    logic             q_big;

    always_comb begin
        // prep: magnitude, shift, and a check that the quotient fits 32 bits
        mag          = num[64] ? -num : num;
        shifted      = NUM_W'(mag[63:0]) << FRAC_BITS;
        top          = 64'(shifted[NUM_W-1:32]);
        rem_next[0]  = top;
        low_next[0]  = shifted[31:0];
        q_next[0]    = '0;
        den_next[0]  = den;
        neg_next[0]  = num[64];
        over_next[0] = (top >= den);
        for (int s = 1; s <= DIV_STEPS; s++) begin
            trial[s]     = {rem_reg[s-1], low_reg[s-1][31]};
            ge[s]        = (trial[s] >= {1'b0, den_reg[s-1]});
            rem_next[s]  = ge[s] ? 64'(trial[s] - {1'b0, den_reg[s-1]}) : trial[s][63:0];
            low_next[s]  = {low_reg[s-1][30:0], 1'b0};
            q_next[s]    = {q_reg[s-1][30:0], ge[s]};
            den_next[s]  = den_reg[s-1];
            neg_next[s]  = neg_reg[s-1];
            over_next[s] = over_reg[s-1];
        end
        limit = neg_reg[DIV_STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q_big = over_reg[DIV_STEPS] || (q_reg[DIV_STEPS] > limit);
        sat_next = q_big;
        if (q_big) quo_next = limit;
        else if (neg_reg[DIV_STEPS]) quo_next = -q_reg[DIV_STEPS];
        else quo_next = q_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                q_reg[s]    <= q_next[s];
                den_reg[s]  <= den_next[s];
                neg_reg[s]  <= neg_next[s];
                over_reg[s] <= over_next[s];
            end
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;
endmodule

[rtl/core/cau_back.sv]
// back end: products, sums, saturation and two dividers in one stalling pipeline
// depends on cau_pkg, cau_div
module cau_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  cau_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,
    output logic [1:0]     m_tuser
);
    import cau_pkg::*;

    logic en;

    // stage 1: products and add/sub sums
    logic               s1_valid_reg;
    action_t            s1_act_reg;
    logic               s1_divz_reg;
    logic signed [63:0] s1_ac_reg, s1_bd_reg, s1_ad_reg, s1_bc_reg, s1_cc_reg, s1_dd_reg;
    logic signed [32:0] s1_sre_reg, s1_sim_reg;

    // stage 2: divider operands and the non-divide result
    logic               s2_valid_reg;
    action_t            s2_act_reg;
    logic               s2_divz_reg;
    logic signed [64:0] s2_nr_reg, s2_ni_reg;
    logic [63:0]        s2_den_reg;
    logic [31:0]        s2_re_reg, s2_im_reg;
    logic               s2_sat_reg;

    logic signed [64:0] wr, wi;
    sat_t               re_next, im_next;

    // bypass line alongside the divider
    logic        bp_valid_reg [0:DIV_LAT-1];
    action_t     bp_act_reg   [0:DIV_LAT-1];
    logic        bp_divz_reg  [0:DIV_LAT-1];
    logic [31:0] bp_re_reg    [0:DIV_LAT-1];
    logic [31:0] bp_im_reg    [0:DIV_LAT-1];
    logic        bp_sat_reg   [0:DIV_LAT-1];

    logic [31:0] dq_re, dq_im;
    logic        dsat_re, dsat_im;

    logic        out_valid_reg;
    logic [31:0] out_re_reg, out_re_next;
    logic [31:0] out_im_reg, out_im_next;
    logic [1:0]  out_stat_reg, out_stat_next;

    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && !q_empty;

    always_comb begin
        wr = 65'(s1_ac_reg) - 65'(s1_bd_reg);
        wi = 65'(s1_ad_reg) + 65'(s1_bc_reg);
        if (s1_act_reg == ACT_MUL) begin
            re_next = sat32(wr >>> FRAC_BITS);
            im_next = sat32(wi >>> FRAC_BITS);
        end else begin
            re_next = sat32(65'(s1_sre_reg));
            im_next = sat32(65'(s1_sim_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) bp_valid_reg[i] <= 1'b0;
        end else if (en) begin
            s1_valid_reg    <= !q_empty;
            s2_valid_reg    <= s1_valid_reg;
            bp_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < DIV_LAT; i++) bp_valid_reg[i] <= bp_valid_reg[i-1];
            out_valid_reg   <= bp_valid_reg[DIV_LAT-1];
        end
        if (en) begin
            s1_act_reg  <= q_item.action;
            s1_divz_reg <= q_item.div_zero;
            s1_ac_reg   <= q_item.a_real * q_item.b_real;
            s1_bd_reg   <= q_item.a_imag * q_item.b_imag;
            s1_ad_reg   <= q_item.a_real * q_item.b_imag;
            s1_bc_reg   <= q_item.a_imag * q_item.b_real;
            s1_cc_reg   <= q_item.b_real * q_item.b_real;
            s1_dd_reg   <= q_item.b_imag * q_item.b_imag;
            if (q_item.action == ACT_SUB) begin
                s1_sre_reg <= 33'(q_item.a_real) - 33'(q_item.b_real);
                s1_sim_reg <= 33'(q_item.a_imag) - 33'(q_item.b_imag);
            end else begin
                s1_sre_reg <= 33'(q_item.a_real) + 33'(q_item.b_real);
                s1_sim_reg <= 33'(q_item.a_imag) + 33'(q_item.b_imag);
            end

            s2_act_reg  <= s1_act_reg;
            s2_divz_reg <= s1_divz_reg;
            s2_nr_reg   <= 65'(s1_ac_reg) + 65'(s1_bd_reg);
            s2_ni_reg   <= 65'(s1_bc_reg) - 65'(s1_ad_reg);
            s2_den_reg  <= $unsigned(s1_cc_reg) + $unsigned(s1_dd_reg);
            s2_re_reg   <= re_next.val;
            s2_im_reg   <= im_next.val;
            s2_sat_reg  <= re_next.sat || im_next.sat;

            bp_act_reg[0]  <= s2_act_reg;
            bp_divz_reg[0] <= s2_divz_reg;
            bp_re_reg[0]   <= s2_re_reg;
            bp_im_reg[0]   <= s2_im_reg;
            bp_sat_reg[0]  <= s2_sat_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                bp_act_reg[i]  <= bp_act_reg[i-1];
                bp_divz_reg[i] <= bp_divz_reg[i-1];
                bp_re_reg[i]   <= bp_re_reg[i-1];
                bp_im_reg[i]   <= bp_im_reg[i-1];
                bp_sat_reg[i]  <= bp_sat_reg[i-1];
            end

            out_re_reg   <= out_re_next;
            out_im_reg   <= out_im_next;
            out_stat_reg <= out_stat_next;
        end
    end

    cau_div u_div_re (
        .aclk (aclk), .en (en), .num (s2_nr_reg), .den (s2_den_reg),
        .quo  (dq_re), .sat (dsat_re)
    );

    cau_div u_div_im (
        .aclk (aclk), .en (en), .num (s2_ni_reg), .den (s2_den_reg),
        .quo  (dq_im), .sat (dsat_im)
    );

    always_comb begin
        if (bp_act_reg[DIV_LAT-1] != ACT_DIV) begin
            out_re_next   = bp_re_reg[DIV_LAT-1];
            out_im_next   = bp_im_reg[DIV_LAT-1];
            out_stat_next = bp_sat_reg[DIV_LAT-1] ? STAT_SAT : STAT_OK;
        end else if (bp_divz_reg[DIV_LAT-1]) begin
            out_re_next   = '0;
            out_im_next   = '0;
            out_stat_next = STAT_DIVZ;
        end else begin
            out_re_next   = dq_re;
            out_im_next   = dq_im;
            out_stat_next = (dsat_re || dsat_im) ? STAT_SAT : STAT_OK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tuser  = out_stat_reg;
endmodule

[rtl/core/complex_arith_unit.sv]
// top level of the complex arithmetic unit: add, subtract, multiply, divide in Q16.16
// depends on cau_pkg, cau_front, cau_fifo, cau_back (and cau_div below it)
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata = a_real, a_imag, b_real, b_imag; s_tuser = action
// m_        out  m_tvalid/m_tready  m_tdata = res_real, res_imag; m_tuser = status
//
// one item per cycle sustained while m_tready stays high
// every item passes the 32-step restoring divider pipeline or the bypass line beside it
// aresetn (synchronous, active low) empties the front register, queue and pipeline
// a stalled m_ side freezes the back pipeline; the four-entry queue and the front
// register keep taking items until they fill
module complex_arith_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag (lowest first)
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_real, res_imag (lowest first)
    output logic [1:0]   m_tuser    // status
);
    import cau_pkg::*;

    // queue handshake between front and back
    logic  q_full, q_push, q_empty, q_pop;
    item_t q_in_item, q_out_item;

    // front classifies the operation and flags a zero divisor
    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    // decoupling queue
    cau_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    // back end does the arithmetic and holds the output register
    cau_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (q_out_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

[tb/cau_checker.sv]
// checker for the complex arithmetic unit: watches both stream channels,
// predicts each result from the operands and compares; depends on cau_pkg
`timescale 1ns / 1ps

module cau_checker
    import cau_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  status;
    } cplx_res_t;

    cplx_res_t expected_results[$];

    function automatic logic [31:0] clamp32(input logic signed [159:0] v, ref logic sat);
        if (v > 160'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -160'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // quotient of num * 2^FRAC_BITS / den truncated toward zero
    function automatic logic signed [159:0] scaled_quot(input logic signed [159:0] num,
                                                        input logic signed [159:0] den);
        logic signed [159:0] mag;
        logic signed [159:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FRAC_BITS) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_res_t complex_result(input logic [1:0] act,
                                                 input logic [127:0] ops);
        cplx_res_t r;
        logic signed [159:0] a, b, c, d, x, y, den;
        logic sat;
        a = $signed(ops[31:0]);
        b = $signed(ops[63:32]);
        c = $signed(ops[95:64]);
        d = $signed(ops[127:96]);
        sat = 1'b0;
        r.status = STAT_OK;
        case (action_t'(act))
            ACT_ADD: begin x = a + c; y = b + d; end
            ACT_SUB: begin x = a - c; y = b - d; end
            ACT_MUL: begin
                x = (a * c - b * d) >>> FRAC_BITS;
                y = (a * d + b * c) >>> FRAC_BITS;
            end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    x = 0; y = 0;
                    r.status = STAT_DIVZ;
                end else begin
                    x = scaled_quot(a * c + b * d, den);
                    y = scaled_quot(b * c - a * d, den);
                end
            end
        endcase
        r.re = clamp32(x, sat);
        r.im = clamp32(y, sat);
        if (r.status == STAT_OK && sat) r.status = STAT_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        cplx_res_t e;
        if (!aresetn) begin
            fail_count = 0;
            results_seen <= 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(complex_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("[%0t] result item with none expected", $realtime);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[31:0] !== e.re)  report_mismatch("res_real", m_tdata[31:0], e.re);
                    if (m_tdata[63:32] !== e.im) report_mismatch("res_imag", m_tdata[63:32], e.im);
                    if (m_tuser !== e.status)    report_mismatch("status", m_tuser, e.status);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/tb_complex_arith_unit.sv]
// testbench top for the complex arithmetic unit: directed and random operand items,
// random idling on both channels, verdict from cau_checker; depends on cau_pkg
`timescale 1ns / 1ps

module tb_complex_arith_unit;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * DIV_LAT + 20;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = ACT_ADD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count, pending, results_seen;

    // idle percentages and a long receiver hold-off request
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  idle_cycles   = 0;
    int  items_sent    = 0;

    always #5 aclk = ~aclk;

    complex_arith_unit u_top (.*);

    cau_checker u_checker (.*);

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request && hold_left == 0) begin
                hold_left = 300;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending);
            $display("Verification failed");
            $finish;
        end
    end

    // send one item, idling first at the current rate
    task automatic send_op(input action_t act, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {bi, br, ai, ar};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom_range(8) - 4;
            3: return $urandom_range(32'h0003_FFFF) - 32'h0002_0000;   // small magnitude
            default: return $urandom;
        endcase
    endfunction

    task automatic random_ops(input int n);
        action_t act;
        logic [31:0] br, bi;
        for (int k = 0; k < n; k++) begin
            act = action_t'($urandom_range(3));
            br = rand_part();
            bi = rand_part();
            // occasional zero divisor
            if (act == ACT_DIV && $urandom_range(15) == 0) begin br = 0; bi = 0; end
            send_op(act, rand_part(), rand_part(), br, bi);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: every action, field extremes, saturation, zero divisor
        send_op(ACT_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        send_op(ACT_ADD, mx, mn, 32'd1, 32'hFFFF_FFFF);   // both parts saturate
        send_op(ACT_ADD, mx, mn, mn, mx);
        send_op(ACT_SUB, mn, mx, 32'd1, 32'hFFFF_FFFF);   // both parts saturate
        send_op(ACT_SUB, 32'h0005_0000, 0, 32'h0002_8000, 32'h0001_0000);
        send_op(ACT_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_op(ACT_MUL, 32'hFFFF_FFFF, 0, 32'd1, 0);      // floor of a negative fraction
        send_op(ACT_MUL, mn, mn, mn, mn);
        send_op(ACT_MUL, mx, mx, mx, mn);
        send_op(ACT_MUL, mn, 0, mn, 0);
        send_op(ACT_DIV, 32'h0001_0000, 0, 32'h0002_0000, 0);
        send_op(ACT_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
        send_op(ACT_DIV, mx, mn, 0, 0);                    // zero divisor
        send_op(ACT_DIV, 0, 0, 0, 0);
        send_op(ACT_DIV, mx, mx, 32'd1, 0);                // quotient saturates
        send_op(ACT_DIV, mn, mn, 32'd1, 32'd1);
        send_op(ACT_DIV, 32'hFFFF_FFFF, 32'd1, 32'h0003_0000, 32'h0007_0000);
        send_op(ACT_DIV, mn, 0, mn, 0);
        send_op(ACT_DIV, 32'd1, 32'hFFFF_FFFF, mn, mx);
        s_tvalid <= 1'b0;

        // sender pauses until everything has come back
        wait_drained();

        send_idle_pct = 19; recv_idle_pct = 59;
        random_ops(450);
        // long receiver hold-off while items keep coming, so the block backs up
        send_idle_pct = 0;
        hold_request = 1'b1;
        random_ops(100);
        send_idle_pct = 59; recv_idle_pct = 19;
        random_ops(500);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_ops(500);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("sent %0d items across add, subtract, multiply and divide", items_sent);
        $display("checked %0d results including saturation and zero-divisor cases",
                 results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_fifo.sv
rtl/core/cau_div.sv
rtl/core/cau_back.sv
rtl/core/complex_arith_unit.sv
tb/cau_checker.sv
tb/tb_complex_arith_unit.sv
